// ===== sv/assert_macros.svh =====
// Assertion macros shared by the voxel face extractor RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted
`define VFE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never hold
`define VFE_NEVER(label, clk, rst_n, cond, msg) \
    `VFE_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

// ===== sv/vfe_pkg.sv =====
// Package for the voxel face extractor: payload structs, axis codes, face code helper.
// No dependencies.
package vfe_pkg;

    localparam int ID_FIELD_W = 16;
    localparam int CELL_W     = 12;
    localparam int CODE_W     = 3;

    typedef struct packed {
        logic [ID_FIELD_W-1:0] block_id;
        logic                  chunk_start;
    } block_item_t;

    typedef struct packed {
        logic [CELL_W-1:0]     cell_index;
        logic [ID_FIELD_W-1:0] face_block_id;
        logic [CODE_W-1:0]     face_code;
        logic                  last_face;
    } face_item_t;

    typedef logic [1:0] axis_t;

    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    function automatic logic [CODE_W-1:0] face_code_f(axis_t axis, logic orient);
        return {axis, orient};
    endfunction

endpackage

// ===== sv/vfe_ram.sv =====
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No dependencies.
module vfe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 289
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem_reg[rd_addr_a];
            rd_b_reg <= mem_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// ===== sv/voxel_face_extractor.sv =====
// Voxel face extractor top level: position tracking, plane buffer, face sequencing.
// Depends on vfe_pkg, vfe_ram and assert_macros.svh.
//
// Usage:
//   block channel (block_valid/block_stall/block_item) takes one block id per
//   transfer, (CHUNK_EDGE+1)^3 per chunk, x fastest, then y, then z, border
//   included. chunk_start on a transfer restarts the chunk at block (0,0,0).
//   face channel (face_valid/face_stall/face_item) gives 0..3 faces per block,
//   last_face set on the final face caused by that block.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes the void id; always ready.
//   A face passes the compare stage, face queue and output register in turn.
//   Throughput: one block per cycle while each block gives at most one face
//   and face_stall is low; otherwise faces leave one at a time, up to 3 per
//   block, through the single face output register fed from the face queue.
//   The previous z plane lives in a (CHUNK_EDGE+1)^2 entry RAM, read at two
//   addresses and written once per block transfer.
//   Reset: position returns to (0,0,0), void id to 0, pipeline empties; the
//   plane RAM is not cleared (its first plane is never compared).
//   A stall on the face channel holds the output; the block channel stalls
//   once the face queue and the stage before it are both full.
module voxel_face_extractor #(
    parameter int CHUNK_EDGE = 16,
    parameter int ID_BITS    = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  block_valid,
    output logic                                  block_stall,
    input  vfe_pkg::block_item_t                  block_item,
    output logic                                  face_valid,
    input  logic                                  face_stall,
    output vfe_pkg::face_item_t                   face_item,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [vfe_pkg::ID_FIELD_W-1:0]        cfg_data
);

    localparam int SIDE   = CHUNK_EDGE + 1;
    localparam int PLANE  = SIDE * SIDE;
    localparam int POS_W  = $clog2(SIDE);
    localparam int SLOT_W = $clog2(PLANE);
    localparam int ID_W   = (ID_BITS < vfe_pkg::ID_FIELD_W) ? ID_BITS : vfe_pkg::ID_FIELD_W;
    localparam int CUBE_W = $clog2(CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE);
    localparam int CW     = (CUBE_W > vfe_pkg::CELL_W) ? CUBE_W : vfe_pkg::CELL_W;
    localparam int SQ     = CHUNK_EDGE * CHUNK_EDGE;

    // configuration
    logic [vfe_pkg::ID_FIELD_W-1:0] empty_reg;
    logic [ID_W-1:0]                void_id;

    // position
    logic [POS_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [POS_W-1:0] pos_x_next, pos_y_next, pos_z_next;
    logic [POS_W-1:0] cx, cy, cz, cz_m1;
    logic [SLOT_W-1:0] slot, addr_a, addr_b;
    logic [SLOT_W:0]   slot_side;
    logic [CW-1:0]     cell_full;
    logic              cur_active;
    logic [ID_W-1:0]   cur_id;
    logic              accept;

    // plane RAM
    logic [ID_W-1:0] ram_rd_a, ram_rd_b;

    // compare stage
    logic                      sa_valid_reg, sa_valid_next;
    logic                      sa_active_reg;
    logic [ID_W-1:0]           sa_cur_reg, sa_b0_reg;
    logic [vfe_pkg::CELL_W-1:0] sa_cell_reg;
    logic [ID_W-1:0]           nb [3];
    logic [ID_W-1:0]           a_id [3];
    logic [2:0]                a_mask;
    logic                      a_orient;
    logic                      a_void0;
    logic                      sa_adv;
    logic                      load_b;

    // face queue
    logic [2:0]                fb_mask_reg, fb_mask_next;
    logic [ID_W-1:0]           fb_id_reg [3];
    logic [vfe_pkg::CELL_W-1:0] fb_cell_reg;
    logic                      fb_orient_reg;
    vfe_pkg::axis_t            sel_axis;
    logic [2:0]                fb_rest;
    logic                      emit;
    logic                      b_free;

    // output
    logic                      out_valid_reg, out_valid_next;
    vfe_pkg::face_item_t       out_data_reg;
    logic                      out_free;

    assign cfg_ready = 1'b1;
    assign void_id   = empty_reg[ID_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_reg <= '0;
        end
        else if (cfg_valid)
        begin
            empty_reg <= cfg_data;
        end
    end

    // ---- input side ----
    assign accept = block_valid && !block_stall;
    assign cur_id = block_item.block_id[ID_W-1:0];

    always_comb
    begin
        cx = block_item.chunk_start ? '0 : pos_x_reg;
        cy = block_item.chunk_start ? '0 : pos_y_reg;
        cz = block_item.chunk_start ? '0 : pos_z_reg;
        cz_m1 = cz - POS_W'(1);

        slot = SLOT_W'(cx) + SLOT_W'(cy) * SLOT_W'(SIDE);
        addr_a = (slot == SLOT_W'(PLANE - 1)) ? '0 : slot + SLOT_W'(1);
        slot_side = (SLOT_W+1)'(slot) + (SLOT_W+1)'(SIDE);
        addr_b = (slot_side >= (SLOT_W+1)'(PLANE)) ? SLOT_W'(slot_side - (SLOT_W+1)'(PLANE))
                                                   : SLOT_W'(slot_side);

        cur_active = (cz != '0) && (cx != POS_W'(CHUNK_EDGE)) && (cy != POS_W'(CHUNK_EDGE));
        cell_full = CW'(cx) + CW'(cy) * CW'(CHUNK_EDGE) + CW'(cz_m1) * CW'(SQ);

        pos_x_next = cx;
        pos_y_next = cy;
        pos_z_next = cz;
        if (cx != POS_W'(CHUNK_EDGE))
        begin
            pos_x_next = cx + POS_W'(1);
        end
        else
        begin
            pos_x_next = '0;
            if (cy != POS_W'(CHUNK_EDGE))
            begin
                pos_y_next = cy + POS_W'(1);
            end
            else
            begin
                pos_y_next = '0;
                pos_z_next = (cz != POS_W'(CHUNK_EDGE)) ? cz + POS_W'(1) : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
        end
        else if (accept)
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            pos_z_reg <= pos_z_next;
        end
    end

    // addr_a reads the next block's own cell, addr_b the cell one row ahead
    vfe_ram #(
        .WIDTH (ID_W),
        .DEPTH (PLANE)
    ) u_plane (
        .clk       (clk),
        .wr_en     (accept),
        .wr_addr   (slot),
        .wr_data   (cur_id),
        .rd_en     (accept),
        .rd_addr_a (addr_a),
        .rd_addr_b (addr_b),
        .rd_data_a (ram_rd_a),
        .rd_data_b (ram_rd_b)
    );

    // ---- compare stage ----
    always_comb
    begin
        nb[0]    = ram_rd_a;
        nb[1]    = ram_rd_b;
        nb[2]    = sa_cur_reg;
        a_void0  = (sa_b0_reg == void_id);
        a_orient = !a_void0;
        for (int a = 0; a < 3; a++)
        begin
            a_mask[a] = sa_active_reg && (a_void0 != (nb[a] == void_id));
            a_id[a]   = a_orient ? sa_b0_reg : nb[a];
        end
    end

    assign sa_adv      = sa_valid_reg && ((a_mask == '0) || b_free);
    assign load_b      = sa_valid_reg && (a_mask != '0) && b_free;
    assign block_stall = sa_valid_reg && !sa_adv;

    always_comb
    begin
        sa_valid_next = sa_valid_reg;
        if (accept)
        begin
            sa_valid_next = 1'b1;
        end
        else if (sa_adv)
        begin
            sa_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_valid_reg <= 1'b0;
        end
        else
        begin
            sa_valid_reg <= sa_valid_next;
        end
    end

    // b0 is the previous transfer's addr_a read, still on the RAM output
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sa_cur_reg    <= cur_id;
            sa_b0_reg     <= ram_rd_a;
            sa_active_reg <= cur_active;
            sa_cell_reg   <= cell_full[vfe_pkg::CELL_W-1:0];
        end
    end

    // ---- face queue ----
    always_comb
    begin
        sel_axis = vfe_pkg::AXIS_X;
        priority if (fb_mask_reg[0])
        begin
            sel_axis = vfe_pkg::AXIS_X;
        end
        else if (fb_mask_reg[1])
        begin
            sel_axis = vfe_pkg::AXIS_Y;
        end
        else
        begin
            sel_axis = vfe_pkg::AXIS_Z;
        end
        fb_rest = fb_mask_reg & ~(3'(3'b001 << sel_axis));
    end

    assign out_free = !out_valid_reg || !face_stall;
    assign emit     = (fb_mask_reg != '0) && out_free;
    assign b_free   = (fb_mask_reg == '0) || (emit && (fb_rest == '0));

    always_comb
    begin
        fb_mask_next = fb_mask_reg;
        if (load_b)
        begin
            fb_mask_next = a_mask;
        end
        else if (emit)
        begin
            fb_mask_next = fb_rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_mask_reg <= '0;
        end
        else
        begin
            fb_mask_reg <= fb_mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_b)
        begin
            fb_id_reg[0]  <= a_id[0];
            fb_id_reg[1]  <= a_id[1];
            fb_id_reg[2]  <= a_id[2];
            fb_cell_reg   <= sa_cell_reg;
            fb_orient_reg <= a_orient;
        end
    end

    // ---- output register ----
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!face_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg.cell_index    <= fb_cell_reg;
            out_data_reg.face_block_id <= vfe_pkg::ID_FIELD_W'(fb_id_reg[sel_axis]);
            out_data_reg.face_code     <= vfe_pkg::face_code_f(sel_axis, fb_orient_reg);
            out_data_reg.last_face     <= (fb_rest == '0);
        end
    end

    assign face_valid = out_valid_reg;
    assign face_item  = out_data_reg;

    // ---- checks ----
`include "assert_macros.svh"

    `VFE_ASSERT(held_item_chk, clk, rst_n, (sa_valid_reg && block_stall) |=> (sa_valid_reg && $stable(sa_cell_reg)), "compare stage lost a stalled block")
    `VFE_ASSERT(queue_rest_chk, clk, rst_n, (emit && (fb_rest != '0)) |=> (fb_mask_reg != '0), "face queue dropped pending faces")
    `VFE_NEVER(code_range_chk, clk, rst_n, out_valid_reg && (out_data_reg.face_code > vfe_pkg::face_code_f(vfe_pkg::AXIS_Z, 1'b1)), "face code out of range")
    `VFE_NEVER(pos_range_chk, clk, rst_n, (pos_x_reg > POS_W'(CHUNK_EDGE)) || (pos_y_reg > POS_W'(CHUNK_EDGE)) || (pos_z_reg > POS_W'(CHUNK_EDGE)), "position beyond chunk border")

endmodule
